// File: src/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg - shared types and constants for the SHA-256 byte stream hasher
// Transaction structs, round constants, initial hash values, control structs.
// ----------------------------------------------------------------------------
package sbsh_pkg;

  typedef logic [7:0][31:0] word_vec_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_item_t;

  // Command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Padding
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [5:0] LAST_BYTE   = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;

  typedef struct packed {
    logic       start;
    logic       init;
    logic       byte_we;
    logic [7:0] byte_val;
  } sbsh_core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sbsh_core_st_t;

  function automatic word_vec_t initial_h();
    word_vec_t h;
    h[0] = 32'h6a09e667;
    h[1] = 32'hbb67ae85;
    h[2] = 32'h3c6ef372;
    h[3] = 32'ha54ff53a;
    h[4] = 32'h510e527f;
    h[5] = 32'h9b05688c;
    h[6] = 32'h1f83d9ab;
    h[7] = 32'h5be0cd19;
    return h;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// File: src/sbsh_core.sv
// ----------------------------------------------------------------------------
// sbsh_core - SHA-256 compression engine, one round per cycle
// Holds the chaining words and a 64-byte line that is the block buffer while
// bytes arrive and the rolling message schedule while rounds run.
// ----------------------------------------------------------------------------
module sbsh_core
  import sbsh_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  sbsh_core_ctl_t ctl,
  output sbsh_core_st_t  st,
  output word_vec_t      hash
);

  logic [511:0] buf_r;      // byte 0 of the block sits at the top
  word_vec_t    h_r;
  word_vec_t    v_r;
  logic [5:0]   rnd_r;
  logic         busy_r;
  logic         fin_r;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0] t1, t2, bs0, bs1, ch, maj;

  assign w0  = buf_r[511:480];
  assign w1  = buf_r[479:448];
  assign w9  = buf_r[223:192];
  assign w14 = buf_r[63:32];

  // w[t+16] from the window that starts at w[t]
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign bs1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign bs0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + bs1 + ch + round_k(rnd_r) + w0;
  assign t2  = bs0 + maj;

  assign st.busy = busy_r;
  assign st.done = busy_r & fin_r;
  assign hash    = h_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else if (busy_r) begin
      if (fin_r) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b0;
      end else begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          fin_r <= 1'b1;
        end
      end
    end
  end

  // Chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= initial_h();
    end else if (ctl.init) begin
      h_r <= initial_h();
    end else if (busy_r && fin_r) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  // Working variables and block line (payload, no reset)
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v_r <= h_r;
    end else if (busy_r && !fin_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (ctl.byte_we) begin
      buf_r <= {buf_r[503:0], ctl.byte_val};
    end else if (busy_r && !fin_r) begin
      buf_r <= {buf_r[479:0], w_new};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("compression started while busy");
  a_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.byte_we |-> !busy_r) else $error("byte written during compression");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && fin_r) |=> !busy_r) else $error("engine busy after done");
  a_fin_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> $past(rnd_r) == LAST_ROUND) else $error("early finalize");

endmodule

// File: src/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher - SHA-256 over a stream of byte transactions
// Append bytes, finish with padding and length, stream out the digest.
// ----------------------------------------------------------------------------
// An append transaction (cmd 0) stores its byte; the 64th byte of a block
// starts the compression engine, which runs 64 rounds at one round per
// cycle and then folds the result into the chaining words, while in_ready
// stays low. A finish transaction (cmd 1) writes the 0x80 mark, then one pad
// byte per cycle up to offset 56, then the eight length bytes (true message
// bit count, big-endian), running the engine on each block it fills: one
// block, or two when 56 or more bytes were held. The digest then leaves as
// eight result transactions, word 0 (most significant) first, last set on
// word 7, and the block is ready for the next message. On a long message
// the single shared round unit sets the pace.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
  import sbsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,  // engine busy
    S_PAD   = 5'b00100,  // zero fill up to offset 56
    S_LEN   = 5'b01000,  // length bytes
    S_EMIT  = 5'b10000   // digest words out
  } state_t;

  state_t         state_r, state_nxt;
  state_t         ret_r, ret_nxt;       // where to go after the engine
  logic [5:0]     cnt_r, cnt_nxt;       // bytes held in the block
  logic [63:0]    bits_r, bits_nxt;     // message length in bits
  logic [63:0]    len_r, len_nxt;       // length being shifted out
  logic [2:0]     widx_r, widx_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  sbsh_core_ctl_t core_ctl;
  sbsh_core_st_t  core_st;
  word_vec_t      hash;

  logic in_acc, out_free;

  sbsh_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (core_ctl),
    .st   (core_st),
    .hash (hash)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    bits_nxt      = bits_r;
    len_nxt       = len_r;
    widx_nxt      = widx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    core_ctl      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          core_ctl.byte_we = 1'b1;
          cnt_nxt          = cnt_r + 6'd1;
          if (in_data.cmd == CMD_APPEND) begin
            core_ctl.byte_val = in_data.data_byte;
            bits_nxt          = bits_r + 64'd8;
            ret_nxt           = S_IDLE;
          end else begin
            // finish: latch the length and write the pad mark
            core_ctl.byte_val = PAD_MARK;
            len_nxt           = bits_r;
            ret_nxt           = S_PAD;
            state_nxt         = S_PAD;
          end
          if (cnt_r == LAST_BYTE) begin
            core_ctl.start = 1'b1;
            state_nxt      = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        if (core_st.done) begin
          state_nxt = ret_r;
        end
      end
      S_PAD: begin
        if (cnt_r == LEN_OFFSET) begin
          state_nxt = S_LEN;
        end else begin
          core_ctl.byte_we  = 1'b1;
          core_ctl.byte_val = 8'h00;
          cnt_nxt           = cnt_r + 6'd1;
          if (cnt_r == LAST_BYTE) begin
            // mark landed at or past offset 56: zeros fill this block, then another
            core_ctl.start = 1'b1;
            ret_nxt        = S_PAD;
            state_nxt      = S_ROUND;
          end
        end
      end
      S_LEN: begin
        core_ctl.byte_we  = 1'b1;
        core_ctl.byte_val = len_r[63:56];
        len_nxt           = {len_r[55:0], 8'h00};
        cnt_nxt           = cnt_r + 6'd1;
        if (cnt_r == LAST_BYTE) begin
          core_ctl.start = 1'b1;
          ret_nxt        = S_EMIT;
          widx_nxt       = '0;
          state_nxt      = S_ROUND;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = hash[widx_r];
          out_data_nxt.word_index  = widx_r;
          out_data_nxt.last        = (widx_r == LAST_WORD);
          widx_nxt                 = widx_r + 3'd1;
          if (widx_r == LAST_WORD) begin
            // reinitialize for the next message
            core_ctl.init = 1'b1;
            bits_nxt      = '0;
            cnt_nxt       = '0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      bits_r      <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      bits_r      <= bits_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
  end

  a_idle_engine: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !core_st.busy) else $error("engine busy in idle");
  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r == 6'd0)) else $error("bytes held at emit");
  a_start_full: assert property (@(posedge clk) disable iff (!rst_n)
    core_ctl.start |=> (cnt_r == 6'd0)) else $error("engine started on partial block");

endmodule

// File: tb/tb_sha256_byte_stream_hasher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher - self-checking bench for the SHA-256 hasher
// A table of directed transactions checks known digests and the edge cases.
// Random messages follow, some with lengths around the padding boundaries.
// An in-bench SHA-256 model predicts each digest word that has no typed-in
// digest, and a scoreboard compares each output transaction against it.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;
  import sbsh_pkg::*;

  localparam int N_DIR        = 14;    // rows in the directed table
  localparam int RAND_ITEMS   = 140;   // random transactions, rounded up to a message
  localparam int DRAIN_CYCLES = 260;   // two-block finish, worst case, plus margin
  localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
  localparam int MAX_REPORTS  = 10;

  // Digests that are well known: the empty string and "abc".
  localparam logic [255:0] DIG_EMPTY =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] DIG_ABC =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  // Round constants and initial chaining words, kept here so the model does
  // not take them from the package.
  localparam logic [0:63][31:0] K_TAB = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [0:7][31:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One directed row: the transaction, plus an optional typed-in digest.
  typedef struct packed {
    logic         cmd;
    logic [7:0]   data_byte;
    logic         has_known;
    logic [255:0] known;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  initial begin
    forever #5 clk = ~clk;
  end

  sha256_byte_stream_hasher i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Hash model state: chaining words, partial block, byte and bit counts
  // --------------------------------------------------------------------------
  logic [31:0] chain_w [8];
  logic [7:0]  blk_buf [64];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  out_item_t   digest_q [$];   // digest words still owed by the DUT
  stim_row_t   dir_rows [N_DIR];

  int err_cnt       = 0;
  int words_checked = 0;
  int bytes_sent    = 0;
  int finishes_sent = 0;
  int two_block_cnt = 0;
  int longest_msg   = 0;
  int burst_left    = 0;
  int idle_cyc      = 0;
  logic [9:0] rdy_cyc = '0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_reinit();
    for (int i = 0; i < 8; i++) chain_w[i] = H_INIT[i];
    blk_fill = '0;
    msg_bits = '0;
  endfunction

  // 64 rounds over the full block, schedule kept as a rolling 16-word window.
  function automatic void hash_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    a = chain_w[0]; b = chain_w[1]; c = chain_w[2]; d = chain_w[3];
    e = chain_w[4]; f = chain_w[5]; g = chain_w[6]; h = chain_w[7];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        wt = s1 + w[(t-7)&15] + s0 + w[t&15];
        w[t&15] = wt;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + K_TAB[t] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_w[0] += a; chain_w[1] += b; chain_w[2] += c; chain_w[3] += d;
    chain_w[4] += e; chain_w[5] += f; chain_w[6] += g; chain_w[7] += h;
  endfunction

  function automatic void hash_put(input logic [7:0] v);
    blk_buf[blk_fill] = v;
    blk_fill = blk_fill + 6'd1;   // wraps at 64
    if (blk_fill == 6'd0) hash_compress();
  endfunction

  // Applies one accepted transaction; returns the digest on a finish.
  function automatic logic [255:0] hash_apply(input in_item_t it);
    logic [63:0] len;
    logic [255:0] dig;
    dig = '0;
    if (it.cmd == CMD_APPEND) begin
      msg_bits += 64'd8;
      hash_put(it.data_byte);
      bytes_sent++;
    end else begin
      len = msg_bits;
      if (blk_fill >= LEN_OFFSET) two_block_cnt++;
      if (int'(len >> 3) > longest_msg) longest_msg = int'(len >> 3);
      hash_put(PAD_MARK);
      while (blk_fill != LEN_OFFSET) hash_put(8'h00);
      for (int i = 0; i < 8; i++) hash_put(len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) dig[255-32*i -: 32] = chain_w[i];
      hash_reinit();
      finishes_sent++;
    end
    return dig;
  endfunction

  function automatic void owe_digest(input logic [255:0] dig);
    out_item_t o;
    for (int i = 0; i < 8; i++) begin
      o.digest_word = dig[255-32*i -: 32];
      o.word_index  = i[2:0];
      o.last        = (i[2:0] == LAST_WORD);
      digest_q.push_back(o);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one transaction per call, in bursts with random gaps.
  // Valid stays up across a burst; it drops only when a gap is taken.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input logic use_known,
                           input logic [255:0] known);
    logic [255:0] dig;
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dig = hash_apply(it);
    if (it.cmd == CMD_FINISH) owe_digest(use_known ? known : dig);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst, so whole blocks go in without gaps
      burst_left = ($urandom_range(0, 7) == 0) ? 70 : $urandom_range(1, 24);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: back-pressure pattern that cycles through modes
  // (always ready, coin flip, mostly stalled, periodic).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rdy_cyc <= rdy_cyc + 10'd1;
    case (rdy_cyc[9:7])
      3'd0, 3'd4: out_ready <= 1'b1;
      3'd1, 3'd5: out_ready <= 1'($urandom_range(0, 1));
      3'd2:       out_ready <= ($urandom_range(0, 3) == 0);
      3'd3:       out_ready <= (rdy_cyc[1:0] == 2'b11);
      default:    out_ready <= (rdy_cyc[2:0] != 3'd0);
    endcase
  end

  // Scoreboard: each output transaction against the oldest owed word.
  always @(posedge clk) begin : chk_digest
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        note_mismatch($sformatf("unexpected digest word %h idx %0d last %0b",
                                out_data.digest_word, out_data.word_index,
                                out_data.last));
      end else begin
        want = digest_q.pop_front();
        words_checked++;
        if (out_data.digest_word !== want.digest_word ||
            out_data.word_index !== want.word_index ||
            out_data.last !== want.last) begin
          note_mismatch($sformatf(
            "digest word: expected %h idx %0d last %0b, got %h idx %0d last %0b",
            want.digest_word, want.word_index, want.last,
            out_data.digest_word, out_data.word_index, out_data.last));
        end
      end
    end
  end

  // Watchdog: a run with no transaction on either side for this long is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d words owed",
                 IDLE_LIMIT, digest_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_item_t it;
    int rnd_items;
    int msg_no;
    int msg_len;

    // Directed table. Message length overflow past 2^64 bits is out of reach
    // in simulation, so it is left to review.
    dir_rows = '{
      '{CMD_FINISH, 8'h00, 1'b1, DIG_EMPTY},  // empty message right after reset
      '{CMD_FINISH, 8'hff, 1'b1, DIG_EMPTY},  // finish after finish; byte ignored
      '{CMD_APPEND, 8'h61, 1'b0, 256'h0},     // "abc"
      '{CMD_APPEND, 8'h62, 1'b0, 256'h0},
      '{CMD_APPEND, 8'h63, 1'b0, 256'h0},
      '{CMD_FINISH, 8'h00, 1'b1, DIG_ABC},
      '{CMD_APPEND, 8'h00, 1'b0, 256'h0},     // byte extremes
      '{CMD_APPEND, 8'hff, 1'b0, 256'h0},
      '{CMD_FINISH, 8'h5a, 1'b0, 256'h0},
      '{CMD_APPEND, 8'h80, 1'b0, 256'h0},     // data equal to the pad mark
      '{CMD_APPEND, 8'h55, 1'b0, 256'h0},
      '{CMD_APPEND, 8'haa, 1'b0, 256'h0},
      '{CMD_FINISH, 8'ha5, 1'b0, 256'h0},
      '{CMD_FINISH, 8'h00, 1'b1, DIG_EMPTY}   // empty again after a real message
    };

    hash_reinit();
    burst_left = $urandom_range(1, 24);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      it.cmd       = dir_rows[r].cmd;
      it.data_byte = dir_rows[r].data_byte;
      send_item(it, dir_rows[r].has_known, dir_rows[r].known);
    end

    // Random messages. The first pads into a second block, the second
    // crosses a full block while appending; after that mostly short ones,
    // with the odd empty message and lengths around the 56/64 boundaries.
    rnd_items = 0;
    msg_no    = 0;
    while (rnd_items < RAND_ITEMS) begin
      if (msg_no == 0) begin
        msg_len = $urandom_range(56, 63);
      end else if (msg_no == 1) begin
        msg_len = $urandom_range(64, 72);
      end else begin
        case ($urandom_range(0, 9))
          0:       msg_len = 0;
          1:       msg_len = $urandom_range(52, 66);
          default: msg_len = $urandom_range(1, 12);
        endcase
      end
      for (int i = 0; i < msg_len; i++) begin
        it.cmd       = CMD_APPEND;
        it.data_byte = 8'($urandom_range(0, 255));
        send_item(it, 1'b0, 256'h0);
      end
      it.cmd       = CMD_FINISH;
      it.data_byte = 8'($urandom_range(0, 255));
      send_item(it, 1'b0, 256'h0);
      rnd_items += msg_len + 1;
      msg_no++;
    end
    in_valid <= 1'b0;

    // Drain: every owed word, then a quiet period to catch stray outputs.
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d byte and %0d finish transactions, %0d digest words checked",
             bytes_sent, finishes_sent, words_checked);
    $display("longest message %0d bytes, %0d finishes padded into a second block",
             longest_msg, two_block_cnt);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d words still owed", err_cnt, digest_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
src/sbsh_pkg.sv
src/sbsh_core.sv
src/sha256_byte_stream_hasher.sv
tb/tb_sha256_byte_stream_hasher.sv
